FILE: rtl/obv_pkg.sv
// Shared types, widths and constants for the omni-wheel body velocity core.
// Used by obv_matrix, obv_cell, obv_scale and the top level; depends on nothing.
package obv_pkg;

  localparam int WHEEL_W = 16;
  localparam int TAG_W   = 4;
  localparam int XY_W    = 34;
  localparam int W_W     = 34;
  localparam int PH_W    = 33;
  localparam int STEP_W  = 5;
  localparam int STEPS   = 24;
  localparam int VEL_W   = 17;
  localparam int RATE_W  = 20;
  localparam int SPLIT   = 17;
  localparam int GAIN_W  = 31;
  localparam int SUM_W   = 65;
  localparam int RND_W   = SUM_W - 44;
  localparam int WR_W    = W_W + 1 - 14;

  localparam logic signed [17:0] K_XA = 18'sd4257;
  localparam logic signed [17:0] K_XB = 18'sd3617;
  localparam logic signed [17:0] K_Y  = 18'sd4835;
  localparam logic signed [17:0] K_WA = 18'sd37988;
  localparam logic signed [17:0] K_WB = 18'sd29791;

  localparam logic signed [GAIN_W-1:0] INV_GAIN = 31'sd652032874;

  localparam logic signed [VEL_W-1:0]  VEL_MAX  = 17'sd65535;
  localparam logic signed [VEL_W-1:0]  VEL_MIN  = -17'sd65536;
  localparam logic signed [RATE_W-1:0] RATE_MAX = 20'sd524287;
  localparam logic signed [RATE_W-1:0] RATE_MIN = -20'sd524288;

  typedef struct packed {
    logic                     valid;
    logic [TAG_W-1:0]         tag;
    logic signed [W_W-1:0]    w;
  } side_t;

  function automatic logic signed [PH_W-1:0] arctan(input logic [STEP_W-1:0] step);
    logic signed [PH_W-1:0] a;
    case (step)
      5'd0:    a = 33'sd536870912;
      5'd1:    a = 33'sd316933406;
      5'd2:    a = 33'sd167458907;
      5'd3:    a = 33'sd85004756;
      5'd4:    a = 33'sd42667331;
      5'd5:    a = 33'sd21354465;
      5'd6:    a = 33'sd10679838;
      5'd7:    a = 33'sd5340245;
      5'd8:    a = 33'sd2670163;
      5'd9:    a = 33'sd1335087;
      5'd10:   a = 33'sd667544;
      5'd11:   a = 33'sd333772;
      5'd12:   a = 33'sd166886;
      5'd13:   a = 33'sd83443;
      5'd14:   a = 33'sd41721;
      5'd15:   a = 33'sd20860;
      5'd16:   a = 33'sd10430;
      5'd17:   a = 33'sd5215;
      5'd18:   a = 33'sd2607;
      5'd19:   a = 33'sd1303;
      5'd20:   a = 33'sd651;
      5'd21:   a = 33'sd325;
      5'd22:   a = 33'sd162;
      5'd23:   a = 33'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/omni_wheel_body_velocity_core.sv
// Omni-wheel body velocity core: wheel matrix, 24-cell rotator chain, gain and saturation.
// Throughput: one word per cycle; the 30-stage pipeline freezes only while the skid
// register is full. Reset (rst, synchronous) empties the pipeline, output and skid
// registers; no clearing pass. Depends on obv_pkg, obv_matrix, obv_cell, obv_scale.
module omni_wheel_body_velocity_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [obv_pkg::TAG_W-1:0]         robot_number,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_a,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_b,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_c,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_d,
  input  logic signed [obv_pkg::WHEEL_W-1:0] heading,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [obv_pkg::TAG_W-1:0]         robot_tag,
  output logic signed [obv_pkg::VEL_W-1:0]  velocity_x,
  output logic signed [obv_pkg::VEL_W-1:0]  velocity_y,
  output logic signed [obv_pkg::RATE_W-1:0] angular_rate
);

  logic                              advance;
  logic                              skid_valid;
  logic [obv_pkg::TAG_W-1:0]         skid_tag;
  logic signed [obv_pkg::VEL_W-1:0]  skid_vx, skid_vy;
  logic signed [obv_pkg::RATE_W-1:0] skid_rate;

  obv_pkg::side_t                    side  [0:obv_pkg::STEPS];
  logic signed [obv_pkg::XY_W-1:0]   cx    [0:obv_pkg::STEPS];
  logic signed [obv_pkg::XY_W-1:0]   cy    [0:obv_pkg::STEPS];
  logic signed [obv_pkg::PH_W-1:0]   cph   [0:obv_pkg::STEPS];
  logic [obv_pkg::STEP_W-1:0]        cstep [0:obv_pkg::STEPS];

  logic                              last_valid;
  logic [obv_pkg::TAG_W-1:0]         last_tag;
  logic signed [obv_pkg::VEL_W-1:0]  last_vx, last_vy;
  logic signed [obv_pkg::RATE_W-1:0] last_rate;
  logic                              take_out;

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;
  assign cstep[0] = '0;
  assign take_out = !out_valid || !out_stall;

  obv_matrix u_matrix (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .valid        (in_valid),
    .robot_number (robot_number),
    .wheel_a      (wheel_a),
    .wheel_b      (wheel_b),
    .wheel_c      (wheel_c),
    .wheel_d      (wheel_d),
    .heading      (heading),
    .side         (side[0]),
    .x            (cx[0]),
    .y            (cy[0]),
    .ph           (cph[0])
  );

  for (genvar i = 0; i < obv_pkg::STEPS; i++) begin : g_cell
    obv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .step     (cstep[i]),
      .side_in  (side[i]),
      .x_in     (cx[i]),
      .y_in     (cy[i]),
      .ph_in    (cph[i]),
      .step_out (cstep[i+1]),
      .side     (side[i+1]),
      .x        (cx[i+1]),
      .y        (cy[i+1]),
      .ph       (cph[i+1])
    );
  end

  obv_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .side_in (side[obv_pkg::STEPS]),
    .x_in    (cx[obv_pkg::STEPS]),
    .y_in    (cy[obv_pkg::STEPS]),
    .valid   (last_valid),
    .tag     (last_tag),
    .vel_x   (last_vx),
    .vel_y   (last_vy),
    .rate    (last_rate)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out) begin
      out_valid  <= skid_valid || last_valid;
      skid_valid <= 1'b0;
    end else if (last_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      if (skid_valid) begin
        robot_tag    <= skid_tag;
        velocity_x   <= skid_vx;
        velocity_y   <= skid_vy;
        angular_rate <= skid_rate;
      end else begin
        robot_tag    <= last_tag;
        velocity_x   <= last_vx;
        velocity_y   <= last_vy;
        angular_rate <= last_rate;
      end
    end else if (!skid_valid) begin
      skid_tag  <= last_tag;
      skid_vx   <= last_vx;
      skid_vy   <= last_vy;
      skid_rate <= last_rate;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_valid && out_stall |=> skid_valid && out_valid)
    else $error("skid word dropped under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !skid_valid)
    else $error("output not empty after reset");

endmodule

FILE: rtl/obv_matrix.sv
// Wheel matrix front end: pair sums, constant products, half-plane fold of heading.
// Three register stages; depends on obv_pkg.
module obv_matrix (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid,
  input  logic [obv_pkg::TAG_W-1:0]         robot_number,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_a,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_b,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_c,
  input  logic signed [obv_pkg::WHEEL_W-1:0] wheel_d,
  input  logic signed [obv_pkg::WHEEL_W-1:0] heading,
  output obv_pkg::side_t                    side,
  output logic signed [obv_pkg::XY_W-1:0]   x,
  output logic signed [obv_pkg::XY_W-1:0]   y,
  output logic signed [obv_pkg::PH_W-1:0]   ph
);

  logic                              v0, v1;
  logic [obv_pkg::TAG_W-1:0]         tag0, tag1;
  logic signed [obv_pkg::WHEEL_W-1:0] hd0, hd1;
  logic signed [16:0]                da, bc_d, ad, bc;
  logic signed [17:0]                yq;
  logic signed [obv_pkg::XY_W-1:0]   x1, y1;
  logic signed [obv_pkg::W_W-1:0]    w1;
  logic                              hi, lo;
  logic signed [16:0]                hd_fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      v0 <= valid;
      v1 <= v0;
      side.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0 <= robot_number;
      hd0  <= heading;
      da   <= 17'(wheel_a) - 17'(wheel_d);
      bc_d <= 17'(wheel_b) - 17'(wheel_c);
      ad   <= 17'(wheel_a) + 17'(wheel_d);
      bc   <= 17'(wheel_b) + 17'(wheel_c);
      yq   <= 18'(wheel_b) + 18'(wheel_c) - 18'(wheel_a) - 18'(wheel_d);

      tag1 <= tag0;
      hd1  <= hd0;
      x1   <= obv_pkg::XY_W'(obv_pkg::K_XA) * obv_pkg::XY_W'(da)
            + obv_pkg::XY_W'(obv_pkg::K_XB) * obv_pkg::XY_W'(bc_d);
      y1   <= obv_pkg::XY_W'(obv_pkg::K_Y) * obv_pkg::XY_W'(yq);
      w1   <= -(obv_pkg::W_W'(obv_pkg::K_WA) * obv_pkg::W_W'(ad)
            + obv_pkg::W_W'(obv_pkg::K_WB) * obv_pkg::W_W'(bc));

      side.tag <= tag1;
      side.w   <= w1;
      x        <= (hi || lo) ? -x1 : x1;
      y        <= (hi || lo) ? -y1 : y1;
      ph       <= {hd_fold, 16'b0};
    end
  end

  always_comb begin
    hi = hd1 > 16'sd16384;
    lo = hd1 < -16'sd16384;
    if (hi) begin
      hd_fold = 17'(hd1) - 17'sd32768;
    end else if (lo) begin
      hd_fold = 17'(hd1) + 17'sd32768;
    end else begin
      hd_fold = 17'(hd1);
    end
  end

endmodule

FILE: rtl/obv_cell.sv
// One rotation step of the vector rotator chain; step index arrives from the left neighbor.
// Depends on obv_pkg for widths, sideband type and the arctangent table.
module obv_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [obv_pkg::STEP_W-1:0]        step,
  input  obv_pkg::side_t                    side_in,
  input  logic signed [obv_pkg::XY_W-1:0]   x_in,
  input  logic signed [obv_pkg::XY_W-1:0]   y_in,
  input  logic signed [obv_pkg::PH_W-1:0]   ph_in,
  output logic [obv_pkg::STEP_W-1:0]        step_out,
  output obv_pkg::side_t                    side,
  output logic signed [obv_pkg::XY_W-1:0]   x,
  output logic signed [obv_pkg::XY_W-1:0]   y,
  output logic signed [obv_pkg::PH_W-1:0]   ph
);

  logic signed [obv_pkg::XY_W-1:0] xs, ys;
  logic signed [obv_pkg::PH_W-1:0] at;

  assign step_out = step + 1'b1;
  assign xs = x_in >>> step;
  assign ys = y_in >>> step;
  assign at = obv_pkg::arctan(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.tag <= side_in.tag;
      side.w   <= side_in.w;
      if (!ph_in[obv_pkg::PH_W-1]) begin
        x  <= x_in - ys;
        y  <= y_in + xs;
        ph <= ph_in - at;
      end else begin
        x  <= x_in + ys;
        y  <= y_in - xs;
        ph <= ph_in + at;
      end
    end
  end

endmodule

FILE: rtl/obv_scale.sv
// Back end: rotator gain correction as split products, rounding to 1/1024, saturation.
// Three register stages; depends on obv_pkg.
module obv_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  obv_pkg::side_t                    side_in,
  input  logic signed [obv_pkg::XY_W-1:0]   x_in,
  input  logic signed [obv_pkg::XY_W-1:0]   y_in,
  output logic                              valid,
  output logic [obv_pkg::TAG_W-1:0]         tag,
  output logic signed [obv_pkg::VEL_W-1:0]  vel_x,
  output logic signed [obv_pkg::VEL_W-1:0]  vel_y,
  output logic signed [obv_pkg::RATE_W-1:0] rate
);

  localparam int HI_W = obv_pkg::XY_W - obv_pkg::SPLIT;
  localparam int PH_W = HI_W + obv_pkg::GAIN_W;
  localparam int PL_W = obv_pkg::SPLIT + 1 + obv_pkg::GAIN_W;

  logic                                v0, v1;
  logic [obv_pkg::TAG_W-1:0]           tag0, tag1;
  logic signed [obv_pkg::W_W-1:0]      w0;
  logic signed [PH_W-1:0]              xh_p, yh_p;
  logic signed [PL_W-1:0]              xl_p, yl_p;
  logic signed [obv_pkg::SUM_W-1:0]    xsum, ysum;
  logic signed [obv_pkg::W_W:0]        wsum;
  logic signed [obv_pkg::RND_W-1:0]    xr, yr;
  logic signed [obv_pkg::WR_W-1:0]     wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v0    <= side_in.valid;
      v1    <= v0;
      valid <= v1;
    end
  end

  always_comb begin
    xsum = (obv_pkg::SUM_W'(xh_p) <<< obv_pkg::SPLIT) + obv_pkg::SUM_W'(xl_p)
         + (obv_pkg::SUM_W'(1) <<< 43);
    ysum = (obv_pkg::SUM_W'(yh_p) <<< obv_pkg::SPLIT) + obv_pkg::SUM_W'(yl_p)
         + (obv_pkg::SUM_W'(1) <<< 43);
    wsum = (obv_pkg::W_W + 1)'(w0) + (obv_pkg::W_W + 1)'(8192);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0 <= side_in.tag;
      w0   <= side_in.w;
      xh_p <= PH_W'($signed(x_in[obv_pkg::XY_W-1:obv_pkg::SPLIT]))
            * PH_W'(obv_pkg::INV_GAIN);
      yh_p <= PH_W'($signed(y_in[obv_pkg::XY_W-1:obv_pkg::SPLIT]))
            * PH_W'(obv_pkg::INV_GAIN);
      xl_p <= PL_W'($signed({1'b0, x_in[obv_pkg::SPLIT-1:0]}))
            * PL_W'(obv_pkg::INV_GAIN);
      yl_p <= PL_W'($signed({1'b0, y_in[obv_pkg::SPLIT-1:0]}))
            * PL_W'(obv_pkg::INV_GAIN);

      tag1 <= tag0;
      xr   <= xsum[obv_pkg::SUM_W-1:44];
      yr   <= ysum[obv_pkg::SUM_W-1:44];
      wr   <= wsum[obv_pkg::W_W:14];

      tag <= tag1;
      if (xr > obv_pkg::RND_W'(obv_pkg::VEL_MAX)) begin
        vel_x <= obv_pkg::VEL_MAX;
      end else if (xr < obv_pkg::RND_W'(obv_pkg::VEL_MIN)) begin
        vel_x <= obv_pkg::VEL_MIN;
      end else begin
        vel_x <= xr[obv_pkg::VEL_W-1:0];
      end
      if (yr > obv_pkg::RND_W'(obv_pkg::VEL_MAX)) begin
        vel_y <= obv_pkg::VEL_MAX;
      end else if (yr < obv_pkg::RND_W'(obv_pkg::VEL_MIN)) begin
        vel_y <= obv_pkg::VEL_MIN;
      end else begin
        vel_y <= yr[obv_pkg::VEL_W-1:0];
      end
      if (wr > obv_pkg::WR_W'(obv_pkg::RATE_MAX)) begin
        rate <= obv_pkg::RATE_MAX;
      end else if (wr < obv_pkg::WR_W'(obv_pkg::RATE_MIN)) begin
        rate <= obv_pkg::RATE_MIN;
      end else begin
        rate <= wr[obv_pkg::RATE_W-1:0];
      end
    end
  end

endmodule
